/* src/lzd_pkg.sv */
package lzd_pkg;

   localparam int unsigned SIZE_W    = 24;
   localparam int unsigned BACK_W    = 13;
   localparam int unsigned COUNT_W   = 5;
   localparam int unsigned MIN_MATCH = 3;

   localparam logic [3:0] LZ77_TYPE_CODE = 4'h1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_TYPE = 2'd1;
   localparam logic [1:0] STATUS_BAD_DIST = 2'd2;

   typedef struct packed {
      logic [1:0] status;
      logic       last;
      logic       has_byte;
      logic [7:0] data;
   } rsp_item_type;

endpackage

/* src/lz77_stream_decompressor_unit.sv */
// A literal word shows on rsp in the cycle after it is accepted. A valid token of N bytes (3..18)
// holds off the input after its low word: a setup state, then a read and a write state per byte on
// the history RAM, which has one read port and one write port. A result waiting in the output
// register holds off the input; rsp stalls hold the copy. Reset is synchronous, active high:
// control returns to awaiting start.
module lz77_stream_decompressor_unit
   import lzd_pkg::*;
#(
   parameter int unsigned WINDOW_BYTES = 4096
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tuser,   // [0] start_req
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,
   output logic [2:0] rsp_tuser    // [0] has_byte, [2:1] status
);

   localparam int unsigned ADDR_W = $clog2(WINDOW_BYTES);

   rsp_item_type      item;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   lzd_seq #(
      .WINDOW_BYTES (WINDOW_BYTES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_byte  (req_tdata),
      .req_start (req_tuser),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (item),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   lzd_history #(
      .WINDOW_BYTES (WINDOW_BYTES)
   ) u_history (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tdata = item.data;
   assign rsp_tlast = item.last;
   assign rsp_tuser = {item.status, item.has_byte};

endmodule

/* src/lzd_history.sv */
module lzd_history #(
   parameter int unsigned WINDOW_BYTES = 4096
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(WINDOW_BYTES)-1:0] wr_addr,
   input  logic [7:0]                      wr_data,
   input  logic                            rd_en,
   input  logic [$clog2(WINDOW_BYTES)-1:0] rd_addr,
   output logic [7:0]                      rd_data
);

   logic [7:0] mem_ff [WINDOW_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/lzd_seq.sv */
module lzd_seq
   import lzd_pkg::*;
#(
   parameter int unsigned WINDOW_BYTES = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_byte,
   input  logic                            req_start,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output rsp_item_type                    rsp_item,
   output logic                            wr_en,
   output logic [$clog2(WINDOW_BYTES)-1:0] wr_addr,
   output logic [7:0]                      wr_data,
   output logic                            rd_en,
   output logic [$clog2(WINDOW_BYTES)-1:0] rd_addr,
   input  logic [7:0]                      rd_data
);

   localparam int unsigned ADDR_W = $clog2(WINDOW_BYTES);
   localparam int unsigned PTR_W  = ADDR_W + 1;

   typedef enum logic [3:0] {
      ST_DONE,
      ST_HDR1,
      ST_HDR2,
      ST_HDR3,
      ST_FLAG,
      ST_ITEM,
      ST_TOKLO,
      ST_SETUP,
      ST_READ,
      ST_WRITE
   } state_type;

   state_type          state_ff, state_in;
   logic [SIZE_W-1:0]  target_ff, target_in;
   logic [SIZE_W-1:0]  produced_ff, produced_in;
   logic [7:0]         flag_shift_ff, flag_shift_in;
   logic [3:0]         items_left_ff, items_left_in;
   logic [7:0]         token_high_ff, token_high_in;
   logic [BACK_W-1:0]  back_ff, back_in;
   logic [COUNT_W-1:0] copy_left_ff, copy_left_in;
   logic [ADDR_W-1:0]  wptr_ff, wptr_in;
   logic [ADDR_W-1:0]  rptr_ff, rptr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   logic               accepting;
   logic               slot_free;
   logic               take;
   logic [SIZE_W-1:0]  produced_inc;
   logic               fin;
   logic [BACK_W-1:0]  tok_back;
   logic               bad_dist;
   logic [PTR_W-1:0]   ext_w;
   logic [PTR_W-1:0]   ext_b;
   logic [PTR_W-1:0]   wrap_sum;
   logic [ADDR_W-1:0]  rptr_start;
   logic [ADDR_W-1:0]  wptr_next;
   logic [ADDR_W-1:0]  rptr_next;
   logic [3:0]         items_dec;
   state_type          item_state;
   logic               new_valid;
   rsp_item_type       new_item;

   assign accepting = (state_ff != ST_SETUP) && (state_ff != ST_READ) &&
                      (state_ff != ST_WRITE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = accepting && slot_free;
   assign take      = req_valid && req_ready;

   assign produced_inc = produced_ff + SIZE_W'(1);
   assign fin          = produced_inc >= target_ff;

   assign tok_back = {1'b0, token_high_ff[3:0], req_byte} + BACK_W'(1);
   assign bad_dist = SIZE_W'(tok_back) > produced_ff;

   assign ext_w      = PTR_W'(wptr_ff);
   assign ext_b      = PTR_W'(back_ff);
   assign wrap_sum   = ext_w + PTR_W'(WINDOW_BYTES) - ext_b;
   assign rptr_start = (ext_w >= ext_b) ? ADDR_W'(ext_w - ext_b) : wrap_sum[ADDR_W-1:0];

   assign wptr_next = (wptr_ff == ADDR_W'(WINDOW_BYTES - 1)) ? '0 : wptr_ff + ADDR_W'(1);
   assign rptr_next = (rptr_ff == ADDR_W'(WINDOW_BYTES - 1)) ? '0 : rptr_ff + ADDR_W'(1);

   assign items_dec  = items_left_ff - 4'd1;
   assign item_state = (items_dec == 4'd0) ? ST_FLAG : ST_ITEM;

   always_comb begin
      state_in      = state_ff;
      target_in     = target_ff;
      produced_in   = produced_ff;
      flag_shift_in = flag_shift_ff;
      items_left_in = items_left_ff;
      token_high_in = token_high_ff;
      back_in       = back_ff;
      copy_left_in  = copy_left_ff;
      wptr_in       = wptr_ff;
      rptr_in       = rptr_ff;
      new_valid     = 1'b0;
      new_item      = '0;
      wr_en         = 1'b0;
      wr_data       = req_byte;

      unique case (state_ff)
         ST_SETUP: begin
            rptr_in  = rptr_start;
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (slot_free) begin
               new_valid         = 1'b1;
               new_item.data     = rd_data;
               new_item.has_byte = 1'b1;
               new_item.last     = fin;
               new_item.status   = STATUS_OK;
               wr_en             = 1'b1;
               wr_data           = rd_data;
               wptr_in           = wptr_next;
               rptr_in           = rptr_next;
               produced_in       = produced_inc;
               copy_left_in      = copy_left_ff - COUNT_W'(1);
               if (fin) begin
                  state_in = ST_DONE;
               end else if (copy_left_ff == COUNT_W'(1)) begin
                  flag_shift_in = {flag_shift_ff[6:0], 1'b0};
                  items_left_in = items_dec;
                  state_in      = item_state;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            if (take) begin
               if (req_start) begin
                  target_in     = '0;
                  produced_in   = '0;
                  flag_shift_in = '0;
                  items_left_in = '0;
                  token_high_in = '0;
                  wptr_in       = '0;
                  if (req_byte[7:4] != LZ77_TYPE_CODE) begin
                     state_in        = ST_DONE;
                     new_valid       = 1'b1;
                     new_item.last   = 1'b1;
                     new_item.status = STATUS_BAD_TYPE;
                  end else begin
                     state_in = ST_HDR1;
                  end
               end else begin
                  unique case (state_ff)
                     ST_HDR1: begin
                        target_in = SIZE_W'(req_byte);
                        state_in  = ST_HDR2;
                     end
                     ST_HDR2: begin
                        target_in = target_ff | {8'd0, req_byte, 8'd0};
                        state_in  = ST_HDR3;
                     end
                     ST_HDR3: begin
                        target_in = target_ff | {req_byte, 16'd0};
                        if ((target_ff | {req_byte, 16'd0}) == '0) begin
                           state_in        = ST_DONE;
                           new_valid       = 1'b1;
                           new_item.last   = 1'b1;
                           new_item.status = STATUS_OK;
                        end else begin
                           state_in = ST_FLAG;
                        end
                     end
                     ST_FLAG: begin
                        flag_shift_in = req_byte;
                        items_left_in = 4'd8;
                        state_in      = ST_ITEM;
                     end
                     ST_ITEM: begin
                        if (flag_shift_ff[7]) begin
                           token_high_in = req_byte;
                           state_in      = ST_TOKLO;
                        end else begin
                           new_valid         = 1'b1;
                           new_item.data     = req_byte;
                           new_item.has_byte = 1'b1;
                           new_item.last     = fin;
                           new_item.status   = STATUS_OK;
                           wr_en             = 1'b1;
                           wptr_in           = wptr_next;
                           produced_in       = produced_inc;
                           if (fin) begin
                              state_in = ST_DONE;
                           end else begin
                              flag_shift_in = {flag_shift_ff[6:0], 1'b0};
                              items_left_in = items_dec;
                              state_in      = item_state;
                           end
                        end
                     end
                     ST_TOKLO: begin
                        back_in      = tok_back;
                        copy_left_in = COUNT_W'(token_high_ff[7:4]) + COUNT_W'(MIN_MATCH);
                        if (bad_dist) begin
                           state_in        = ST_DONE;
                           new_valid       = 1'b1;
                           new_item.last   = 1'b1;
                           new_item.status = STATUS_BAD_DIST;
                        end else begin
                           state_in = ST_SETUP;
                        end
                     end
                     default: begin
                        state_in = ST_DONE;
                     end
                  endcase
               end
            end
         end
      endcase
   end

   assign rsp_valid_in = new_valid ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign rsp_item_in  = new_valid ? new_item : rsp_item_ff;

   always_ff @(posedge clock) begin
      token_high_ff <= token_high_in;
      back_ff       <= back_in;
      rptr_ff       <= rptr_in;
      rsp_item_ff   <= rsp_item_in;
      if (reset) begin
         state_ff      <= ST_DONE;
         target_ff     <= '0;
         produced_ff   <= '0;
         flag_shift_ff <= '0;
         items_left_ff <= '0;
         copy_left_ff  <= '0;
         wptr_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         target_ff     <= target_in;
         produced_ff   <= produced_in;
         flag_shift_ff <= flag_shift_in;
         items_left_ff <= items_left_in;
         copy_left_ff  <= copy_left_in;
         wptr_ff       <= wptr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign wr_addr   = wptr_ff;
   assign rd_en     = (state_ff == ST_READ);
   assign rd_addr   = rptr_ff;

`ifndef SYNTHESIS
   a_no_accept_in_copy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SETUP || state_ff == ST_READ || state_ff == ST_WRITE) |-> !req_ready)
      else $error("input word accepted during copy");

   a_copy_below_target: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (produced_ff < target_ff))
      else $error("copy running past output size");

   a_copy_count_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ || state_ff == ST_WRITE) |-> (copy_left_ff != '0))
      else $error("copy running with zero count");

   a_marker_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_item_ff.has_byte) |-> rsp_item_ff.last)
      else $error("word without data not marked last");

   a_setup_after_token: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SETUP) |-> ($past(state_ff) == ST_TOKLO))
      else $error("copy setup not preceded by token");
`endif

endmodule

/* test/lz77_stream_decompressor_unit_tb.sv */
`timescale 1ns / 100ps

module lz77_stream_decompressor_unit_tb;
   import lzd_pkg::*;

   localparam int unsigned WINDOW     = 4096;
   localparam int unsigned QUIET_MAX  = 2000;
   localparam int unsigned RAND_WORDS = 160;

   typedef enum logic [2:0] {
      AWAIT_START, SIZE_LO, SIZE_MID, SIZE_HI, FLAGS, ITEM, TOKEN_LO
   } parse_phase_type;

   typedef struct packed {
      logic [7:0]   data;
      logic         start;
      logic         typed;
      rsp_item_type want;
   } dir_row_type;

   localparam rsp_item_type NO_RSP       = '0;
   localparam rsp_item_type BAD_TYPE_RSP = '{STATUS_BAD_TYPE, 1'b1, 1'b0, 8'h00};
   localparam rsp_item_type EMPTY_RSP    = '{STATUS_OK, 1'b1, 1'b0, 8'h00};
   localparam rsp_item_type BAD_DIST_RSP = '{STATUS_BAD_DIST, 1'b1, 1'b0, 8'h00};

   localparam dir_row_type DIRECTED [30] = '{
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'h20, 1'b1, 1'b1, BAD_TYPE_RSP},
      '{8'h10, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b1, EMPTY_RSP},
      '{8'h10, 1'b1, 1'b0, NO_RSP},
      '{8'h20, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'h80, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b1, BAD_DIST_RSP},
      '{8'h10, 1'b1, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, NO_RSP},
      '{8'h40, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, NO_RSP},
      '{8'hF0, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'h1F, 1'b1, 1'b0, NO_RSP},
      '{8'h04, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'h40, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'hF0, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'h77, 1'b0, 1'b0, NO_RSP}
   };

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] in_byte
   logic       req_tuser  = 1'b0;    // [0] start_req
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_byte
   logic       rsp_tlast;
   logic [2:0] rsp_tuser;            // [0] has_byte, [2:1] status

   logic        quiet_run  = 1'b0;
   int unsigned stall_left = 0;
   int unsigned calm_left  = 0;
   int unsigned quiet_cycles = 0;
   int unsigned mismatches = 0;
   int unsigned words_sent = 0;

   rsp_item_type decoded_q [$];
   rsp_item_type step_out [$];

   parse_phase_type phase   = AWAIT_START;
   logic [23:0]  size_goal  = '0;
   logic [23:0]  bytes_out  = '0;
   logic [7:0]   flag_bits  = '0;
   logic [3:0]   items_left = '0;
   logic [7:0]   copy_hi    = '0;
   logic [7:0]   window [WINDOW];

   lz77_stream_decompressor_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned idle_span();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic bit emit_byte(logic [7:0] v);
      bit fin;
      window[bytes_out[11:0]] = v;
      bytes_out = bytes_out + 24'd1;
      fin = (bytes_out >= size_goal);
      step_out.push_back('{STATUS_OK, fin, 1'b1, v});
      if (fin) phase = AWAIT_START;
      return fin;
   endfunction

   function automatic void advance_item();
      flag_bits  = flag_bits << 1;
      items_left = items_left - 4'd1;
      phase      = (items_left == 4'd0) ? FLAGS : ITEM;
   endfunction

   function automatic void decode_word(logic [7:0] b, logic s);
      logic [15:0] info;
      logic [23:0] back;
      int unsigned num;
      if (s) begin
         size_goal  = '0;
         bytes_out  = '0;
         flag_bits  = '0;
         items_left = '0;
         copy_hi    = '0;
         if (b[7:4] != LZ77_TYPE_CODE) begin
            phase = AWAIT_START;
            step_out.push_back(BAD_TYPE_RSP);
         end else begin
            phase = SIZE_LO;
         end
         return;
      end
      case (phase)
         SIZE_LO: begin
            size_goal = {16'h0000, b};
            phase = SIZE_MID;
         end
         SIZE_MID: begin
            size_goal[15:8] = b;
            phase = SIZE_HI;
         end
         SIZE_HI: begin
            size_goal[23:16] = b;
            if (size_goal == '0) begin
               phase = AWAIT_START;
               step_out.push_back(EMPTY_RSP);
            end else begin
               phase = FLAGS;
            end
         end
         FLAGS: begin
            flag_bits  = b;
            items_left = 4'd8;
            phase      = ITEM;
         end
         ITEM: begin
            if (flag_bits[7]) begin
               copy_hi = b;
               phase = TOKEN_LO;
            end else if (!emit_byte(b)) begin
               advance_item();
            end
         end
         TOKEN_LO: begin
            info = {copy_hi, b};
            back = {12'h000, info[11:0]} + 24'd1;
            num  = MIN_MATCH + info[15:12];
            if (back > bytes_out) begin
               phase = AWAIT_START;
               step_out.push_back(BAD_DIST_RSP);
               return;
            end
            for (int i = 0; i < num; i++) begin
               if (emit_byte(window[12'(bytes_out - back)])) return;
            end
            advance_item();
         end
         default: phase = AWAIT_START;
      endcase
   endfunction

   task automatic send_word(logic [7:0] d, logic s, bit typed = 1'b0,
                            rsp_item_type want = '0);
      int unsigned gap;
      gap = quiet_run ? 0 : idle_span();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      step_out.delete();
      decode_word(d, s);
      if (typed) begin
         decoded_q.push_back(want);
      end else begin
         foreach (step_out[i]) decoded_q.push_back(step_out[i]);
      end
   endtask

   task automatic random_stream(logic [23:0] size);
      int unsigned cut, n, d, maxd;
      logic [3:0]  nib, len;
      logic [15:0] info;
      nib = 4'($urandom());
      if ($urandom_range(0, 15) == 0) begin
         if (nib == LZ77_TYPE_CODE) nib = ~nib;
         send_word({nib, 4'($urandom())}, 1'b1);
         return;
      end
      send_word({LZ77_TYPE_CODE, nib}, 1'b1);
      send_word(size[7:0], 1'b0);
      send_word(size[15:8], 1'b0);
      send_word(size[23:16], 1'b0);
      cut = 0;
      if (size > 24'd60) cut = $urandom_range(3, 30);
      else if ($urandom_range(0, 15) == 0) cut = $urandom_range(2, 20);
      n = 0;
      while (phase != AWAIT_START && (cut == 0 || n < cut)) begin
         n++;
         if (phase == FLAGS) begin
            send_word(8'($urandom()), 1'b0);
         end else if (!flag_bits[7]) begin
            send_word(8'($urandom()), 1'b0);
         end else begin
            len  = 4'($urandom());
            maxd = (bytes_out > 24'(WINDOW)) ? WINDOW : int'(bytes_out);
            if (maxd == 0 || $urandom_range(0, 15) == 0)
               d = $urandom_range(1, WINDOW);
            else if ($urandom_range(0, 3) == 0)
               d = maxd;
            else
               d = $urandom_range(1, maxd);
            info = {len, 12'(d - 1)};
            send_word(info[15:8], 1'b0);
            send_word(info[7:0], 1'b0);
         end
      end
   endtask

   always @(posedge clock) begin
      if (calm_left == 0) begin
         quiet_run <= ($urandom_range(0, 3) == 0);
         calm_left = $urandom_range(100, 400);
      end else begin
         calm_left--;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (quiet_run) begin
         rsp_tready <= 1'b1;
      end else begin
         stall_left = idle_span();
         rsp_tready <= (stall_left == 0);
      end
   end

   always @(posedge clock) begin
      rsp_item_type got, exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tuser[2:1], rsp_tlast, rsp_tuser[0], rsp_tdata};
         if (decoded_q.size() == 0) begin
            $error("unexpected word: out_byte %0h has_byte %0b last %0b status %0d",
                   got.data, got.has_byte, got.last, got.status);
            mismatches++;
         end else begin
            exp = decoded_q.pop_front();
            if (got.data !== exp.data) begin
               $error("out_byte: expected %0h, got %0h", exp.data, got.data);
               mismatches++;
            end
            if (got.has_byte !== exp.has_byte) begin
               $error("has_byte: expected %0b, got %0b", exp.has_byte, got.has_byte);
               mismatches++;
            end
            if (got.last !== exp.last) begin
               $error("last: expected %0b, got %0b", exp.last, got.last);
               mismatches++;
            end
            if (got.status !== exp.status) begin
               $error("status: expected %0d, got %0d", exp.status, got.status);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_MAX) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      int unsigned base, skipped, k, r;
      logic [23:0] size;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i])
         send_word(DIRECTED[i].data, DIRECTED[i].start, DIRECTED[i].typed, DIRECTED[i].want);

      base = words_sent;
      skipped = 0;
      while (words_sent - base - skipped < RAND_WORDS) begin
         if (phase == AWAIT_START && $urandom_range(0, 5) == 0) begin
            k = $urandom_range(1, 3);
            repeat (k) send_word(8'($urandom()), 1'b0);
            skipped += k;
         end
         r = $urandom_range(0, 19);
         if (r == 0) size = '0;
         else if (r == 1) size = 24'($urandom());
         else size = 24'($urandom_range(1, 60));
         random_stream(size);
      end
      req_tvalid <= 1'b0;

      while (decoded_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* lz77_stream_decompressor_unit.f */
src/lzd_pkg.sv
src/lzd_history.sv
src/lzd_seq.sv
src/lz77_stream_decompressor_unit.sv
test/lz77_stream_decompressor_unit_tb.sv
